>>> src/hsl_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the HSL to RGB converter.
// No dependencies; imported by every module of the block.

package hsl_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int HUE_WIDTH   = 9;
    localparam int LEVEL_WIDTH = 8;
    localparam int COLOR_WIDTH = 32;
    localparam int S_TDATA_WIDTH = 32;

    localparam logic [HUE_WIDTH-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_WIDTH-1:0] HUE_60    = 9'd60;
    localparam logic [HUE_WIDTH-1:0] HUE_120   = 9'd120;
    localparam logic [HUE_WIDTH-1:0] HUE_180   = 9'd180;
    localparam logic [HUE_WIDTH-1:0] HUE_240   = 9'd240;
    localparam logic [HUE_WIDTH-1:0] HUE_300   = 9'd300;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHAN_MAX     = 8'hFF;

    // 60-degree hue sectors: which channel carries chroma and which the ramp
    typedef enum logic [2:0] {
        SEC_RED_UP   = 3'd0,  // r = c, g = x
        SEC_GREEN_DN = 3'd1,  // r = x, g = c
        SEC_GREEN_UP = 3'd2,  // g = c, b = x
        SEC_BLUE_DN  = 3'd3,  // g = x, b = c
        SEC_BLUE_UP  = 3'd4,  // r = x, b = c
        SEC_RED_DN   = 3'd5   // r = c, b = x
    } sector_t;

endpackage

>>> src/hsl_scale.sv
`timescale 1ns / 1ps
// Front two pipeline stages: hue reduction, sector decode and scaling of
// saturation, lightness and hue phase to fixed point. Depends on hsl_pkg.

module hsl_scale import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [HUE_WIDTH-1:0]   hue_degrees,
    input  logic [LEVEL_WIDTH-1:0] saturation_level,
    input  logic [LEVEL_WIDTH-1:0] lightness_level,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sector_t                sector,
    output logic [FRAC_BITS:0]     sat_fx,
    output logic [FRAC_BITS:0]     light_fx,
    output logic [FRAC_BITS:0]     phase_base,
    output logic [12:0]            phase_rem
);

    // code * 2^F / 255 = code * LEVEL_Q + code * LEVEL_R / 255
    localparam int ONE_INT = 1 << FRAC_BITS;
    localparam logic [FRAC_BITS-8:0] LEVEL_Q = (FRAC_BITS-7)'(ONE_INT / 255);
    localparam logic [7:0]           LEVEL_R = 8'(ONE_INT % 255);
    // hue * 2^F / 60 = hue * PHASE_Q + hue * PHASE_R / 60
    localparam logic [FRAC_BITS-6:0] PHASE_Q = (FRAC_BITS-5)'(ONE_INT / 60);
    localparam logic [5:0]           PHASE_R = 6'(ONE_INT % 60);

    // exact floor(y / 255) for y below 255 * 256
    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] t;
        t = {1'b0, y} + 17'(y[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic                 ready1, ready2;
    logic                 v1_reg, v2_reg;

    logic [HUE_WIDTH-1:0] hue_red;
    sector_t              sec1_next, sec1_reg, sec2_reg;
    logic [6:0]           hm1_next, hm1_reg;
    logic [FRAC_BITS:0]   sq1_next, sq1_reg, lq1_next, lq1_reg;
    logic [15:0]          sr1_next, sr1_reg, lr1_next, lr1_reg;

    logic [FRAC_BITS:0]   sat2_next, sat2_reg, light2_next, light2_reg;
    logic [FRAC_BITS:0]   pb2_next, pb2_reg;
    logic [12:0]          pr2_next, pr2_reg;

    assign ready1   = !v1_reg || ready2;
    assign ready2   = !v2_reg || out_ready;
    assign in_ready = ready1;

    // stage 1: wrap hue, pick sector, partial products of the level scaling
    always_comb begin
        hue_red = (hue_degrees >= HUE_FULL) ? hue_degrees - HUE_FULL : hue_degrees;

        if (hue_red < HUE_60) begin
            sec1_next = SEC_RED_UP;
        end else if (hue_red < HUE_120) begin
            sec1_next = SEC_GREEN_DN;
        end else if (hue_red < HUE_180) begin
            sec1_next = SEC_GREEN_UP;
        end else if (hue_red < HUE_240) begin
            sec1_next = SEC_BLUE_DN;
        end else if (hue_red < HUE_300) begin
            sec1_next = SEC_BLUE_UP;
        end else begin
            sec1_next = SEC_RED_DN;
        end

        if (hue_red >= HUE_240) begin
            hm1_next = 7'(hue_red - HUE_240);
        end else if (hue_red >= HUE_120) begin
            hm1_next = 7'(hue_red - HUE_120);
        end else begin
            hm1_next = 7'(hue_red);
        end

        sq1_next = (FRAC_BITS+1)'(saturation_level) * (FRAC_BITS+1)'(LEVEL_Q);
        lq1_next = (FRAC_BITS+1)'(lightness_level) * (FRAC_BITS+1)'(LEVEL_Q);
        sr1_next = 16'(saturation_level) * 16'(LEVEL_R);
        lr1_next = 16'(lightness_level) * 16'(LEVEL_R);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            sec1_reg <= sec1_next;
            hm1_reg  <= hm1_next;
            sq1_reg  <= sq1_next;
            sr1_reg  <= sr1_next;
            lq1_reg  <= lq1_next;
            lr1_reg  <= lr1_next;
        end
    end

    // stage 2: finish level scaling, phase partial products
    always_comb begin
        sat2_next   = sq1_reg + (FRAC_BITS+1)'(div255(sr1_reg));
        light2_next = lq1_reg + (FRAC_BITS+1)'(div255(lr1_reg));
        pb2_next    = (FRAC_BITS+1)'(hm1_reg) * (FRAC_BITS+1)'(PHASE_Q);
        pr2_next    = 13'(hm1_reg) * 13'(PHASE_R);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            sec2_reg   <= sec1_reg;
            sat2_reg   <= sat2_next;
            light2_reg <= light2_next;
            pb2_reg    <= pb2_next;
            pr2_reg    <= pr2_next;
        end
    end

    assign out_valid  = v2_reg;
    assign sector     = sec2_reg;
    assign sat_fx     = sat2_reg;
    assign light_fx   = light2_reg;
    assign phase_base = pb2_reg;
    assign phase_rem  = pr2_reg;

endmodule

>>> src/hsl_chroma.sv
`timescale 1ns / 1ps
// Middle two pipeline stages: chroma, hue ramp component and offset.
// Depends on hsl_pkg.

module hsl_chroma import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sector_t            sector_in,
    input  logic [FRAC_BITS:0] sat_fx,
    input  logic [FRAC_BITS:0] light_fx,
    input  logic [FRAC_BITS:0] phase_base,
    input  logic [12:0]        phase_rem,
    output logic               out_valid,
    input  logic               out_ready,
    output sector_t            sector_out,
    output logic [FRAC_BITS:0] chroma,
    output logic [FRAC_BITS:0] ramp,
    output logic [FRAC_BITS:0] offset
);

    localparam logic [FRAC_BITS:0]   ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+1:0] ONE_X2 = {2'b01, {FRAC_BITS{1'b0}}};
    // floor(y / 60) = (y * 17477) >> 20, exact for y below 7200
    localparam logic [14:0] DIV60_MUL = 15'd17477;

    logic                   ready3, ready4;
    logic                   v3_reg, v4_reg;

    logic [FRAC_BITS+1:0]   lx2, ldist, tw;
    logic [2*FRAC_BITS+1:0] cprod, xprod;
    logic [27:0]            pq;
    sector_t                sec3_reg, sec4_reg;
    logic [FRAC_BITS:0]     chroma3_next, chroma3_reg, phase3_next, phase3_reg;
    logic [FRAC_BITS:0]     light3_reg;

    logic [FRAC_BITS:0]     pdist, u, half_c;
    logic [FRAC_BITS:0]     x4_next, x4_reg, m4_next, m4_reg, chroma4_reg;

    assign ready3   = !v3_reg || ready4;
    assign ready4   = !v4_reg || out_ready;
    assign in_ready = ready3;

    // stage 3: chroma = (1 - |2L - 1|) * S, finish hue phase
    always_comb begin
        lx2          = {light_fx, 1'b0};
        ldist        = (lx2 >= ONE_X2) ? lx2 - ONE_X2 : ONE_X2 - lx2;
        tw           = ONE_X2 - ldist;
        cprod        = (2*FRAC_BITS+2)'(tw[FRAC_BITS:0]) * (2*FRAC_BITS+2)'(sat_fx);
        chroma3_next = cprod[2*FRAC_BITS:FRAC_BITS];
        pq           = 28'(phase_rem) * 28'(DIV60_MUL);
        phase3_next  = phase_base + (FRAC_BITS+1)'(pq[27:20]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ready3) begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && in_valid) begin
            sec3_reg    <= sector_in;
            chroma3_reg <= chroma3_next;
            phase3_reg  <= phase3_next;
            light3_reg  <= light_fx;
        end
    end

    // stage 4: ramp = c * (1 - |P - 1|), offset = L - c/2 floored at zero
    always_comb begin
        pdist   = (phase3_reg >= ONE) ? phase3_reg - ONE : ONE - phase3_reg;
        u       = ONE - pdist;
        xprod   = (2*FRAC_BITS+2)'(chroma3_reg) * (2*FRAC_BITS+2)'(u);
        x4_next = xprod[2*FRAC_BITS:FRAC_BITS];
        half_c  = chroma3_reg >> 1;
        m4_next = (light3_reg > half_c) ? light3_reg - half_c : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ready4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready4 && v3_reg) begin
            sec4_reg    <= sec3_reg;
            chroma4_reg <= chroma3_reg;
            x4_reg      <= x4_next;
            m4_reg      <= m4_next;
        end
    end

    assign out_valid  = v4_reg;
    assign sector_out = sec4_reg;
    assign chroma     = chroma4_reg;
    assign ramp       = x4_reg;
    assign offset     = m4_reg;

endmodule

>>> src/hsl_pack.sv
`timescale 1ns / 1ps
// Last pipeline stage: route chroma and ramp by sector, add the offset,
// scale to 8-bit channels and pack the ARGB word. Depends on hsl_pkg.

module hsl_pack import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sector_t                sector,
    input  logic [FRAC_BITS:0]     chroma,
    input  logic [FRAC_BITS:0]     ramp,
    input  logic [FRAC_BITS:0]     offset,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COLOR_WIDTH-1:0] packed_color
);

    // floor((v + m) * 255 / 2^F), clamped to 255
    function automatic logic [7:0] to_channel(input logic [FRAC_BITS:0] v,
                                              input logic [FRAC_BITS:0] m);
        logic [FRAC_BITS+1:0] sum;
        logic [FRAC_BITS+9:0] prod;
        logic [9:0]           ch;
        sum  = (FRAC_BITS+2)'(v) + (FRAC_BITS+2)'(m);
        prod = ((FRAC_BITS+10)'(sum) << 8) - (FRAC_BITS+10)'(sum);
        ch   = prod[FRAC_BITS+9:FRAC_BITS];
        return (ch > 10'(CHAN_MAX)) ? CHAN_MAX : ch[7:0];
    endfunction

    logic                   v5_reg;
    logic [FRAC_BITS:0]     r_v, g_v, b_v;
    logic [COLOR_WIDTH-1:0] color5_next, color5_reg;

    assign in_ready = !v5_reg || out_ready;

    always_comb begin
        r_v = '0;
        g_v = '0;
        b_v = '0;
        case (sector)
            SEC_RED_UP: begin
                r_v = chroma;
                g_v = ramp;
            end
            SEC_GREEN_DN: begin
                r_v = ramp;
                g_v = chroma;
            end
            SEC_GREEN_UP: begin
                g_v = chroma;
                b_v = ramp;
            end
            SEC_BLUE_DN: begin
                g_v = ramp;
                b_v = chroma;
            end
            SEC_BLUE_UP: begin
                r_v = ramp;
                b_v = chroma;
            end
            default: begin
                r_v = chroma;
                b_v = ramp;
            end
        endcase
        color5_next = {ALPHA_OPAQUE, to_channel(r_v, offset),
                       to_channel(g_v, offset), to_channel(b_v, offset)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (in_ready) begin
            v5_reg <= in_valid;
        end
    end

    // hold the word while the receiver stalls
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            color5_reg <= color5_next;
        end
    end

    assign out_valid    = v5_reg;
    assign packed_color = color5_reg;

endmodule

>>> src/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// HSL to RGB converter, top level. Five register stages, one pixel per clock
// when not stalled. Depends on hsl_pkg, hsl_scale, hsl_chroma and hsl_pack.
//
// Usage:
//   Input channel s_*: one pixel per word, hue in degrees (0..360, 360 is
//   taken as 0; larger codes are reduced by 360), saturation and lightness
//   as 8-bit fractions code/255. A word is taken when s_tvalid and s_tready
//   are both high.
//   Output channel m_*: one ARGB word per input word, in order, alpha 255
//   in bits 31:24, then red, green, blue.
//   Pipeline: five register stages, in hsl_scale, hsl_chroma and hsl_pack;
//   the result word shows on m_tdata from the hsl_pack register.
//   Throughput: one word per clock while m_tready is high, set by the
//   five-stage pipeline with a (FRAC_BITS+1)-bit square multiplier, 17 x 17
//   at the default, in the chroma and ramp stages.
//   Each stage has its own valid bit and ready: while the receiver stalls,
//   the output word holds, and input words keep flowing into empty stages
//   until the pipeline is full; nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge) empties all stages; no word is in
//   flight afterwards and s_tready is high.

module hsl_to_rgb_converter import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [8:0] hue_degrees, [16:9] saturation_level, [24:17] lightness_level
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [31:0] packed_color
    output logic [COLOR_WIDTH-1:0]   m_tdata
);

    logic               sc_valid, sc_ready;
    sector_t            sc_sector;
    logic [FRAC_BITS:0] sc_sat, sc_light, sc_phase_base;
    logic [12:0]        sc_phase_rem;

    logic               ch_valid, ch_ready;
    sector_t            ch_sector;
    logic [FRAC_BITS:0] ch_chroma, ch_ramp, ch_offset;

    hsl_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .hue_degrees      (s_tdata[8:0]),
        .saturation_level (s_tdata[16:9]),
        .lightness_level  (s_tdata[24:17]),
        .out_valid        (sc_valid),
        .out_ready        (sc_ready),
        .sector           (sc_sector),
        .sat_fx           (sc_sat),
        .light_fx         (sc_light),
        .phase_base       (sc_phase_base),
        .phase_rem        (sc_phase_rem)
    );

    hsl_chroma #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chroma (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sc_valid),
        .in_ready   (sc_ready),
        .sector_in  (sc_sector),
        .sat_fx     (sc_sat),
        .light_fx   (sc_light),
        .phase_base (sc_phase_base),
        .phase_rem  (sc_phase_rem),
        .out_valid  (ch_valid),
        .out_ready  (ch_ready),
        .sector_out (ch_sector),
        .chroma     (ch_chroma),
        .ramp       (ch_ramp),
        .offset     (ch_offset)
    );

    hsl_pack #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pack (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (ch_valid),
        .in_ready     (ch_ready),
        .sector       (ch_sector),
        .chroma       (ch_chroma),
        .ramp         (ch_ramp),
        .offset       (ch_offset),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .packed_color (m_tdata)
    );

endmodule

>>> src/hsl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the HSL to RGB converter, bound to the top level.
// Depends on hsl_pkg and hsl_to_rgb_converter.

module hsl_checker import hsl_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [COLOR_WIDTH-1:0] m_tdata
);

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    // an empty output stage lets input flow
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    // alpha is always opaque
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:24] == ALPHA_OPAQUE))
        else $error("alpha byte of output word is not 255");

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed or dropped");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (.*);

>>> tb/hsl_to_rgb_converter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hsl_to_rgb_converter: a fixed-point color model predicts each
// ARGB word, a scoreboard matches results in order under bursty input and stalled output.
// Depends on hsl_pkg and the converter RTL.

module hsl_to_rgb_converter_tb;
    import hsl_pkg::*;

    localparam int RANDOM_PIXELS = 1250;
    localparam int LONG_HOLD     = 120;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct {
        logic [HUE_WIDTH-1:0]   hue;
        logic [LEVEL_WIDTH-1:0] sat;
        logic [LEVEL_WIDTH-1:0] lig;
        logic [COLOR_WIDTH-1:0] color;
    } pixel_expect_t;

    class argb_scoreboard;
        pixel_expect_t expected_colors[$];
        int            error_count = 0;

        // Scale one channel back to a code: truncate, then clamp to 255.
        function logic [7:0] channel_code(logic [63:0] level, logic [63:0] offset);
            logic [63:0] code;
            code = ((level + offset) * 64'd255) >> FRAC_BITS_DEF;
            return (code > 64'd255) ? CHAN_MAX : code[7:0];
        endfunction

        function logic [COLOR_WIDTH-1:0] predict_argb(logic [HUE_WIDTH-1:0] hue_in,
                                                      logic [LEVEL_WIDTH-1:0] sat,
                                                      logic [LEVEL_WIDTH-1:0] lig);
            logic [63:0] one, hue, s_fx, l_fx, span, chroma, phase, ramp, x_fx, half_c, m_fx;
            logic [63:0] red, green, blue;
            sector_t     sector;
            one = 64'd1 << FRAC_BITS_DEF;
            hue = 64'(hue_in);
            if (hue >= HUE_FULL) hue = hue - HUE_FULL;
            s_fx = 64'(sat);
            s_fx = (s_fx << FRAC_BITS_DEF) / 64'd255;
            l_fx = 64'(lig);
            l_fx = (l_fx << FRAC_BITS_DEF) / 64'd255;
            span = (2 * l_fx > one) ? 2 * l_fx - one : one - 2 * l_fx;
            chroma = ((one - span) * s_fx) >> FRAC_BITS_DEF;
            phase = ((hue % HUE_120) << FRAC_BITS_DEF) / HUE_60;
            ramp = (phase > one) ? phase - one : one - phase;
            x_fx = (chroma * (one - ramp)) >> FRAC_BITS_DEF;
            half_c = chroma >> 1;
            m_fx = (l_fx > half_c) ? l_fx - half_c : 64'd0;
            red = 0;
            green = 0;
            blue = 0;
            sector = sector_t'(3'(hue / HUE_60));
            case (sector)
                SEC_RED_UP: begin
                    red = chroma;
                    green = x_fx;
                end
                SEC_GREEN_DN: begin
                    red = x_fx;
                    green = chroma;
                end
                SEC_GREEN_UP: begin
                    green = chroma;
                    blue = x_fx;
                end
                SEC_BLUE_DN: begin
                    green = x_fx;
                    blue = chroma;
                end
                SEC_BLUE_UP: begin
                    red = x_fx;
                    blue = chroma;
                end
                default: begin
                    red = chroma;
                    blue = x_fx;
                end
            endcase
            return {ALPHA_OPAQUE, channel_code(red, m_fx), channel_code(green, m_fx),
                    channel_code(blue, m_fx)};
        endfunction

        function void note_pixel(logic [HUE_WIDTH-1:0] hue, logic [LEVEL_WIDTH-1:0] sat,
                                 logic [LEVEL_WIDTH-1:0] lig);
            pixel_expect_t entry;
            entry.hue = hue;
            entry.sat = sat;
            entry.lig = lig;
            entry.color = predict_argb(hue, sat, lig);
            expected_colors.push_back(entry);
        endfunction

        function void check_color(logic [COLOR_WIDTH-1:0] actual);
            pixel_expect_t entry;
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %08h", $time, actual);
                error_count++;
                return;
            end
            entry = expected_colors.pop_front();
            if (actual !== entry.color) begin
                $display("%0t: color mismatch h=%0d s=%0d l=%0d: expected %08h, actual %08h",
                         $time, entry.hue, entry.sat, entry.lig, entry.color, actual);
                error_count++;
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // [8:0] hue_degrees, [16:9] saturation_level, [24:17] lightness_level
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // [31:0] packed_color
    logic [COLOR_WIDTH-1:0]   m_tdata;

    argb_scoreboard color_board = new();

    hsl_to_rgb_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            color_board.note_pixel(s_tdata[8:0], s_tdata[16:9], s_tdata[24:17]);
        if (aresetn && m_tvalid && m_tready)
            color_board.check_color(m_tdata);
    end

    // Hold the word until the converter takes it; leave tvalid up for the next one.
    task automatic send_pixel(input logic [HUE_WIDTH-1:0] hue,
                              input logic [LEVEL_WIDTH-1:0] sat,
                              input logic [LEVEL_WIDTH-1:0] lig);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, lig, sat, hue};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Receiver: stretches of steady, light and heavy back-pressure, plus one long hold-off.
    initial begin : receiver
        int stretch, mode, k;
        for (k = 0; ; k++) begin
            if (k == 4) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 2);
                stretch = $urandom_range(5, 60);
                repeat (stretch) begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 1) == 0);
                        default: m_tready <= ($urandom_range(0, 6) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        logic [HUE_WIDTH-1:0]   hue;
        logic [LEVEL_WIDTH-1:0] sat, lig;
        logic [LEVEL_WIDTH-1:0] level_corners[6];
        int sent, burst, i;
        level_corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sector edges at full saturation and mid lightness
        send_pixel(9'd0, 8'd255, 8'd128);
        send_pixel(9'd59, 8'd255, 8'd128);
        send_pixel(9'd60, 8'd255, 8'd128);
        send_pixel(9'd119, 8'd255, 8'd128);
        send_pixel(9'd120, 8'd255, 8'd128);
        send_pixel(9'd180, 8'd255, 8'd128);
        send_pixel(9'd240, 8'd255, 8'd128);
        send_pixel(9'd300, 8'd255, 8'd128);
        send_pixel(9'd359, 8'd255, 8'd128);
        // full turn wraps to red; codes past it fold back by 360
        send_pixel(9'd360, 8'd255, 8'd128);
        send_pixel(9'd361, 8'd255, 8'd128);
        send_pixel(9'd511, 8'd255, 8'd255);
        send_pixel(9'd256, 8'd170, 8'd85);
        // gray, black and white
        send_pixel(9'd30, 8'd0, 8'd128);
        send_pixel(9'd90, 8'd255, 8'd0);
        send_pixel(9'd150, 8'd255, 8'd255);
        send_pixel(9'd0, 8'd0, 8'd0);
        send_pixel(9'd511, 8'd0, 8'd0);
        send_pixel(9'd210, 8'd128, 8'd127);
        send_pixel(9'd270, 8'd1, 8'd1);
        send_pixel(9'd330, 8'd254, 8'd254);
        send_pixel(9'd45, 8'd255, 8'd64);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 40);
            for (i = 0; i < burst && sent < RANDOM_PIXELS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: hue = 9'($urandom_range(0, 511));
                    2: hue = 9'(HUE_60 * $urandom_range(0, 6) + $urandom_range(0, 1));
                    default: hue = 9'($urandom_range(0, 360));
                endcase
                sat = ($urandom_range(0, 4) == 0) ? level_corners[$urandom_range(0, 5)]
                                                  : 8'($urandom_range(0, 255));
                lig = ($urandom_range(0, 4) == 0) ? level_corners[$urandom_range(0, 5)]
                                                  : 8'($urandom_range(0, 255));
                send_pixel(hue, sat, lig);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted word before watching the queue
        @(posedge aclk);

        while (color_board.expected_colors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (color_board.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
src/hsl_pkg.sv
src/hsl_scale.sv
src/hsl_chroma.sv
src/hsl_pack.sv
src/hsl_to_rgb_converter.sv
src/hsl_checker.sv
tb/hsl_to_rgb_converter_tb.sv
